### src/erv_pkg.sv
// Shared types, constants, sine table and rounding helpers for the Euler rotation core.
`default_nettype none
package erv_pkg;

    // field and coefficient formats
    localparam int ANGLE_BITS = 16;
    localparam int COORD_BITS = 24;
    localparam int COEF_BITS  = 18;
    localparam int FRAC_BITS  = COEF_BITS - 3;
    localparam int QUAD_SHIFT = ANGLE_BITS - 2;

    // quarter-wave sine table
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int SINE_ROM_N = SINE_DEPTH + 1;
    localparam int ROM_AW     = $clog2(SINE_ROM_N);

    // arithmetic widths
    localparam int PROD_W  = COEF_BITS + COORD_BITS;
    localparam int SUM_W   = PROD_W + 2;
    localparam int MPROD_W = 2 * COEF_BITS;
    localparam int ACC_W   = MPROD_W + 1;
    localparam int RND_W   = 48;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ANGLE_BITS;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = 2'd2;

    typedef logic signed [COEF_BITS-1:0]  t_coef;
    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [ANGLE_BITS-1:0] t_angle;
    typedef logic signed [RND_W-1:0]      t_wide;
    typedef t_coef t_matrix [9];
    typedef t_coef t_sine_rom [SINE_ROM_N];

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    localparam t_coef  COEF_ONE   = t_coef'(1) <<< FRAC_BITS;
    localparam t_angle ANGLE_QTR  = t_angle'(1) << QUAD_SHIFT;
    localparam t_wide  RND_HALF   = t_wide'(1) <<< (FRAC_BITS - 1);
    localparam t_wide  COEF_HI    = (t_wide'(1) <<< (COEF_BITS - 1)) - t_wide'(1);
    localparam t_wide  COEF_LO    = -COEF_HI - t_wide'(1);
    localparam t_wide  COORD_HI   = (t_wide'(1) <<< (COORD_BITS - 1)) - t_wide'(1);
    localparam t_wide  COORD_LO   = -COORD_HI - t_wide'(1);

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = longint'(1) <<< 30;

    // sine table entry i = sin(i*pi/(2*depth)), Taylor series in Q30
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        longint    x;
        longint    x2;
        longint    t;
        longint    s;
        for (int i = 0; i < SINE_ROM_N; i++) begin
            x  = (HALF_PI_Q30 * longint'(i) + longint'(SINE_DEPTH / 2)) / SINE_DEPTH;
            x2 = (x * x) >>> 30;
            t  = ONE_Q30;
            t  = ONE_Q30 - ((x2 * t) >>> 30) / 156;
            t  = ONE_Q30 - ((x2 * t) >>> 30) / 110;
            t  = ONE_Q30 - ((x2 * t) >>> 30) / 72;
            t  = ONE_Q30 - ((x2 * t) >>> 30) / 42;
            t  = ONE_Q30 - ((x2 * t) >>> 30) / 20;
            t  = ONE_Q30 - ((x2 * t) >>> 30) / 6;
            s  = (((x * t) >>> 30) + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            rom[i] = t_coef'(s);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    // drop FRAC_BITS, round half away from zero
    function automatic t_wide round_frac(input t_wide v);
        return (v + RND_HALF - t_wide'(v[RND_W-1])) >>> FRAC_BITS;
    endfunction

    function automatic t_coef sat_coef(input t_wide v);
        if (v > COEF_HI) begin
            return t_coef'(COEF_HI);
        end else if (v < COEF_LO) begin
            return t_coef'(COEF_LO);
        end
        return t_coef'(v);
    endfunction

    function automatic t_coord sat_coord(input t_wide v);
        if (v > COORD_HI) begin
            return t_coord'(COORD_HI);
        end else if (v < COORD_LO) begin
            return t_coord'(COORD_LO);
        end
        return t_coord'(v);
    endfunction

endpackage
`default_nettype wire

### src/erv_point_if.sv
// Input point channel: valid/ready handshake with three Q15.8 coordinates.
`default_nettype none
interface erv_point_if;
    import erv_pkg::*;

    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    t_coord point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface
`default_nettype wire

### src/erv_rot_if.sv
// Rotated point channel: valid/ready handshake with three Q15.8 coordinates.
`default_nettype none
interface erv_rot_if;
    import erv_pkg::*;

    logic   valid;
    logic   ready;
    t_coord rotated_x;
    t_coord rotated_y;
    t_coord rotated_z;

    modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                    input ready);
    modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
                    output ready);
endinterface
`default_nettype wire

### src/euler_rotate_vec3_core.sv
// Top level: Euler-angle rotation of a 3D point stream.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  i_pt     | in  | valid/ready   | point_x, point_y, point_z   (Q15.8)
//  o_rot    | out | valid/ready   | rotated_x, rotated_y, rotated_z (Q15.8)
//  cfg      | in  | i_cfg_we      | i_cfg_idx (0 X, 1 Y, 2 Z), i_cfg_data angle
//
// One point per cycle while o_rot is ready and no rebuild runs, through the multiply
// pipeline. An angle write rebuilds the matrix (six reads of the single-port sine
// ROM, then fourteen products on one shared multiplier); i_pt.ready stays low.
// Synchronous active-low reset: angles 0, identity matrix, pipeline empty.
// Output stalls back up stage by stage; empty stages keep taking requests.
`default_nettype none
module euler_rotate_vec3_core import erv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    erv_point_if.sink             i_pt,
    erv_rot_if.source             o_rot,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg_wr cfg;
    t_matrix mat;
    logic    busy;

    // bundle the write port
    always_comb begin
        cfg.we   = i_cfg_we;
        cfg.idx  = i_cfg_idx;
        cfg.data = i_cfg_data;
    end

    erv_coef_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .o_mat   (mat),
        .o_busy  (busy)
    );

    erv_mac_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat),
        .i_hold  (busy),
        .i_pt    (i_pt),
        .o_rot   (o_rot)
    );

endmodule
`default_nettype wire

### src/erv_coef_gen.sv
// Coefficient builder: angle registers, sine ROM sequencer and shared multiplier.
`default_nettype none
module erv_coef_gen import erv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    output t_matrix o_mat,
    output logic    o_busy
);

    // sequencer steps: ROM reads 0..5, products 7..20, finish at 21
    localparam logic [4:0] STEP_ROM_LAST  = 5'd5;
    localparam logic [4:0] STEP_MUL_FIRST = 5'd7;
    localparam logic [4:0] STEP_DONE      = 5'd21;

    // operand codes (first six match ROM read order)
    localparam logic [2:0] OPD_SX   = 3'd0;
    localparam logic [2:0] OPD_CX   = 3'd1;
    localparam logic [2:0] OPD_SY   = 3'd2;
    localparam logic [2:0] OPD_CY   = 3'd3;
    localparam logic [2:0] OPD_SZ   = 3'd4;
    localparam logic [2:0] OPD_CZ   = 3'd5;
    localparam logic [2:0] OPD_CZSY = 3'd6;
    localparam logic [2:0] OPD_SZSY = 3'd7;

    // product actions
    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_WR   = 3'd1;
    localparam logic [2:0] ACT_TA   = 3'd2;
    localparam logic [2:0] ACT_TB   = 3'd3;
    localparam logic [2:0] ACT_LD   = 3'd4;
    localparam logic [2:0] ACT_ADD  = 3'd5;
    localparam logic [2:0] ACT_SUB  = 3'd6;

    typedef struct packed {
        logic [2:0] a;
        logic [2:0] b;
        logic [2:0] op;
        logic [3:0] dst;
    } t_mstep;

    // product schedule for the nine coefficients
    function automatic t_mstep mul_step(input logic [3:0] idx);
        case (idx)
            4'd0:    return '{OPD_CZ,   OPD_CY, ACT_WR,  4'd0};
            4'd1:    return '{OPD_SZ,   OPD_CY, ACT_WR,  4'd1};
            4'd2:    return '{OPD_CZ,   OPD_SY, ACT_TA,  4'd0};
            4'd3:    return '{OPD_SZ,   OPD_SY, ACT_TB,  4'd0};
            4'd4:    return '{OPD_CY,   OPD_SX, ACT_WR,  4'd5};
            4'd5:    return '{OPD_CZSY, OPD_SX, ACT_LD,  4'd0};
            4'd6:    return '{OPD_SZ,   OPD_CX, ACT_SUB, 4'd3};
            4'd7:    return '{OPD_SZSY, OPD_SX, ACT_LD,  4'd0};
            4'd8:    return '{OPD_CZ,   OPD_CX, ACT_ADD, 4'd4};
            4'd9:    return '{OPD_CZSY, OPD_CX, ACT_LD,  4'd0};
            4'd10:   return '{OPD_SZ,   OPD_SX, ACT_ADD, 4'd6};
            4'd11:   return '{OPD_SZSY, OPD_CX, ACT_LD,  4'd0};
            4'd12:   return '{OPD_CZ,   OPD_SX, ACT_SUB, 4'd7};
            4'd13:   return '{OPD_CY,   OPD_CX, ACT_WR,  4'd8};
            default: return '{OPD_SX,   OPD_SX, ACT_NONE, 4'd0};
        endcase
    endfunction

    t_angle                    r_ang [3];
    logic                      r_busy;
    logic [4:0]                r_step;
    logic                      r_rom_v;
    t_coef                     r_rom_q;
    logic                      r_rom_neg;
    logic [2:0]                r_rom_sel;
    t_coef                     r_sn [6];
    t_coef                     r_czsy;
    t_coef                     r_szsy;
    logic signed [MPROD_W-1:0] r_prod;
    logic signed [MPROD_W-1:0] r_acc;
    logic                      r_act_v;
    logic [2:0]                r_act_op;
    logic [3:0]                r_act_dst;
    t_matrix                   r_mat;

    logic                       cfg_hit;
    logic [1:0]                 ang_idx;
    t_angle                     rd_ang;
    logic [QUAD_SHIFT-1:0]      rd_low;
    logic [QUAD_SHIFT+SINE_AW-1:0] rd_kprod;
    logic [SINE_AW-1:0]         rd_k;
    logic [ROM_AW-1:0]          rom_addr;
    t_mstep                     ms;
    t_coef                      opd_a;
    t_coef                      opd_b;
    logic signed [ACC_W-1:0]    act_sum;
    t_coef                      act_coef;
    t_coef                      act_tmp;

    assign cfg_hit = i_cfg.we && (i_cfg.idx == REG_ANGLE_X || i_cfg.idx == REG_ANGLE_Y ||
                                  i_cfg.idx == REG_ANGLE_Z);

    // ROM address: quadrant fold of sin, cos taken as sin a quarter turn on
    always_comb begin
        ang_idx  = (r_step[2:1] == 2'd3) ? 2'd2 : r_step[2:1];
        rd_ang   = r_ang[ang_idx] + (r_step[0] ? ANGLE_QTR : t_angle'(0));
        rd_low   = rd_ang[QUAD_SHIFT-1:0];
        rd_kprod = {rd_low, SINE_AW'(0)};
        rd_k     = rd_kprod[QUAD_SHIFT+SINE_AW-1:QUAD_SHIFT];
        rom_addr = rd_ang[ANGLE_BITS-2] ? (ROM_AW'(SINE_DEPTH) - ROM_AW'(rd_k))
                                        : ROM_AW'(rd_k);
    end

    // operand select for the shared multiplier
    always_comb begin
        ms = mul_step(4'(r_step - STEP_MUL_FIRST));
        case (ms.a)
            OPD_CZSY: opd_a = r_czsy;
            OPD_SZSY: opd_a = r_szsy;
            default:  opd_a = r_sn[ms.a];
        endcase
        case (ms.b)
            OPD_CZSY: opd_b = r_czsy;
            OPD_SZSY: opd_b = r_szsy;
            default:  opd_b = r_sn[ms.b];
        endcase
    end

    // combine registered product with accumulator, round, saturate
    always_comb begin
        case (r_act_op)
            ACT_ADD: act_sum = ACC_W'(r_acc) + ACC_W'(r_prod);
            ACT_SUB: act_sum = ACC_W'(r_acc) - ACC_W'(r_prod);
            default: act_sum = ACC_W'(r_prod);
        endcase
        act_coef = sat_coef(round_frac(RND_W'(act_sum)));
        act_tmp  = COEF_BITS'(round_frac(RND_W'(r_prod)));
    end

    // control, angles and matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_ang[i] <= '0;
            end
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_rom_v <= 1'b0;
            r_act_v <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_mat[i] <= (i == 0 || i == 4 || i == 8) ? COEF_ONE : t_coef'(0);
            end
        end else begin
            r_rom_v <= r_busy && (r_step <= STEP_ROM_LAST);
            r_act_v <= r_busy && (r_step >= STEP_MUL_FIRST) && (r_step < STEP_DONE);
            if (r_busy) begin
                r_step <= r_step + 5'd1;
                if (r_step == STEP_DONE) begin
                    r_busy   <= 1'b0;
                    r_mat[2] <= -r_sn[OPD_SY];
                end
            end
            if (r_act_v && (r_act_op == ACT_WR || r_act_op == ACT_ADD ||
                            r_act_op == ACT_SUB)) begin
                r_mat[r_act_dst] <= act_coef;
            end
            // an angle write restarts the rebuild
            if (cfg_hit) begin
                r_ang[i_cfg.idx] <= i_cfg.data;
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_rom_v <= 1'b0;
                r_act_v <= 1'b0;
            end
        end
    end

    // ROM read, sine values and multiplier datapath
    always_ff @(posedge i_clk) begin
        r_rom_q   <= SINE_ROM[rom_addr];
        r_rom_neg <= rd_ang[ANGLE_BITS-1];
        r_rom_sel <= r_step[2:0];
        if (r_rom_v) begin
            r_sn[r_rom_sel] <= r_rom_neg ? -r_rom_q : r_rom_q;
        end
        r_prod    <= MPROD_W'(opd_a) * MPROD_W'(opd_b);
        r_act_op  <= ms.op;
        r_act_dst <= ms.dst;
        if (r_act_v) begin
            case (r_act_op)
                ACT_TA:  r_czsy <= act_tmp;
                ACT_TB:  r_szsy <= act_tmp;
                ACT_LD:  r_acc  <= r_prod;
                default: ;
            endcase
        end
    end

    assign o_mat  = r_mat;
    assign o_busy = r_busy;

endmodule
`default_nettype wire

### src/erv_mac_pipe.sv
// Four-stage matrix-vector pipeline: input, products, row sums, round and saturate.
`default_nettype none
module erv_mac_pipe import erv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_matrix          i_mat,
    input  logic             i_hold,
    erv_point_if.sink        i_pt,
    erv_rot_if.source        o_rot
);

    logic                     r_s1_v;
    t_coord                   r_s1_p [3];
    logic                     r_s2_v;
    logic signed [PROD_W-1:0] r_s2_prod [9];
    logic                     r_s3_v;
    logic signed [SUM_W-1:0]  r_s3_sum [3];
    logic                     r_s4_v;
    t_coord                   r_s4_r [3];

    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic take;

    // a stage loads when empty or when its successor loads
    always_comb begin
        en4  = !r_s4_v || o_rot.ready;
        en3  = !r_s3_v || en4;
        en2  = !r_s2_v || en3;
        en1  = !r_s1_v || en2;
        take = i_pt.valid && en1 && !i_hold;
    end

    assign i_pt.ready = en1 && !i_hold;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (en1) r_s1_v <= take;
            if (en2) r_s2_v <= r_s1_v;
            if (en3) r_s3_v <= r_s2_v;
            if (en4) r_s4_v <= r_s3_v;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_p[0] <= i_pt.point_x;
            r_s1_p[1] <= i_pt.point_y;
            r_s1_p[2] <= i_pt.point_z;
        end
        if (en2) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_s2_prod[3*i+j] <= PROD_W'(i_mat[3*i+j]) * PROD_W'(r_s1_p[j]);
                end
            end
        end
        if (en3) begin
            for (int i = 0; i < 3; i++) begin
                r_s3_sum[i] <= SUM_W'(r_s2_prod[3*i]) + SUM_W'(r_s2_prod[3*i+1]) +
                               SUM_W'(r_s2_prod[3*i+2]);
            end
        end
        if (en4) begin
            for (int i = 0; i < 3; i++) begin
                r_s4_r[i] <= sat_coord(round_frac(RND_W'(r_s3_sum[i])));
            end
        end
    end

    assign o_rot.valid     = r_s4_v;
    assign o_rot.rotated_x = r_s4_r[0];
    assign o_rot.rotated_y = r_s4_r[1];
    assign o_rot.rotated_z = r_s4_r[2];

endmodule
`default_nettype wire

### src/erv_checker.sv
// Port-level assertions for the rotation core, bound to the top level.
`default_nettype none
module erv_checker import erv_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input t_coord               i_out_x,
    input t_coord               i_out_y,
    input t_coord               i_out_z,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx
);

    localparam logic [2:0] PIPE_DEPTH = 3'd4;

    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    // requests in flight
    always_comb begin
        n_cnt = r_cnt + 3'(i_in_valid && i_in_ready) - 3'(i_out_valid && i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x) &&
                                        $stable(i_out_y) && $stable(i_out_z))
        else $error("stalled result changed");

    // no result without a request in flight
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 3'd0)
        else $error("result with nothing in flight");

    // pipeline never holds more than its stages
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= PIPE_DEPTH)
        else $error("more requests in flight than stages");

    // an angle write blocks new points while the matrix is rebuilt
    a_rebuild_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx == REG_ANGLE_X || i_cfg_idx == REG_ANGLE_Y ||
                     i_cfg_idx == REG_ANGLE_Z) |=> !i_in_ready)
        else $error("input ready during coefficient rebuild");

endmodule

bind euler_rotate_vec3_core erv_checker u_erv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_rot.valid),
    .i_out_ready (o_rot.ready),
    .i_out_x     (o_rot.rotated_x),
    .i_out_y     (o_rot.rotated_y),
    .i_out_z     (o_rot.rotated_z),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx)
);
`default_nettype wire

### tb/sv/euler_rotate_vec3_core_tb.sv
// Self-checking testbench for the Euler rotation core: angle setups, point stream, result check.
`timescale 1ns / 100ps
module euler_rotate_vec3_core_tb;
    import erv_pkg::*;

    // sine table generation, Q30
    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
    localparam longint UNIT_Q30         = 64'sd1073741824;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam t_coord COORD_TOP    = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord COORD_BOTTOM = {1'b1, {(COORD_BITS-1){1'b0}}};

    // pause longer than a rebuild and a pipeline pass before any write
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_PHASES   = 30;
    localparam int PHASE_ITEMS   = 45;
    localparam int QUIET_PHASE   = 7;
    localparam int HOLD_PHASE    = 12;
    localparam int PAUSE_PHASE   = 18;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
    } vec3_t;

    // predicts rotated points from the current angles and holds them in order
    class rotation_scoreboard;
        longint      sine_q15 [SINE_DEPTH+1];
        longint      coef_q15 [9];
        t_angle      angle_reg [3];
        vec3_t       expected_q [$];
        int unsigned checked;
        int unsigned errors;

        function new();
            longint x;
            longint x2;
            longint t;
            for (int i = 0; i <= SINE_DEPTH; i++) begin
                x  = (QUARTER_TURN_Q30 * i + SINE_DEPTH / 2) / SINE_DEPTH;
                x2 = (x * x) >>> 30;
                t  = UNIT_Q30;
                for (int k = 12; k >= 2; k -= 2) begin
                    t = UNIT_Q30 - ((x2 * t) >>> 30) / (k * (k + 1));
                end
                sine_q15[i] = round_half_away((x * t) >>> 30, 30 - FRAC_BITS);
            end
            checked = 0;
            errors  = 0;
            for (int i = 0; i < 3; i++) begin
                angle_reg[i] = '0;
            end
            // identity after reset
            for (int i = 0; i < 9; i++) begin
                coef_q15[i] = (i % 4 == 0) ? (longint'(1) <<< FRAC_BITS) : 0;
            end
        endfunction

        function longint round_half_away(longint v, int sh);
            longint mag;
            mag = (v < 0) ? -v : v;
            mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
            return (v < 0) ? -mag : mag;
        endfunction

        function longint clamp_signed(longint v, int bits);
            longint hi;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            if (v > hi) begin
                return hi;
            end else if (v < -hi - 1) begin
                return -hi - 1;
            end
            return v;
        endfunction

        function longint to_coef(longint v);
            return clamp_signed(round_half_away(v, FRAC_BITS), COEF_BITS);
        endfunction

        // quarter-wave lookup: top two bits pick the quadrant
        function longint sine_lookup(t_angle a);
            logic [1:0] quad;
            longint     k;
            longint     v;
            quad = a[ANGLE_BITS-1 -: 2];
            k = (longint'(a[ANGLE_BITS-3:0]) * SINE_DEPTH) >> (ANGLE_BITS - 2);
            if (k > SINE_DEPTH) begin
                k = SINE_DEPTH;
            end
            v = quad[0] ? sine_q15[SINE_DEPTH - k] : sine_q15[k];
            return quad[1] ? -v : v;
        endfunction

        function longint cosine_lookup(t_angle a);
            t_angle shifted;
            shifted = a + ANGLE_QTR;
            return sine_lookup(shifted);
        endfunction

        // Z, then Y, then X
        function void rebuild_matrix();
            longint sx, cx, sy, cy, sz, cz, czsy, szsy;
            sx = sine_lookup(angle_reg[0]);
            cx = cosine_lookup(angle_reg[0]);
            sy = sine_lookup(angle_reg[1]);
            cy = cosine_lookup(angle_reg[1]);
            sz = sine_lookup(angle_reg[2]);
            cz = cosine_lookup(angle_reg[2]);
            czsy = round_half_away(cz * sy, FRAC_BITS);
            szsy = round_half_away(sz * sy, FRAC_BITS);
            coef_q15[0] = to_coef(cz * cy);
            coef_q15[1] = to_coef(sz * cy);
            coef_q15[2] = clamp_signed(-sy, COEF_BITS);
            coef_q15[3] = to_coef(czsy * sx - sz * cx);
            coef_q15[4] = to_coef(szsy * sx + cz * cx);
            coef_q15[5] = to_coef(cy * sx);
            coef_q15[6] = to_coef(czsy * cx + sz * sx);
            coef_q15[7] = to_coef(szsy * cx - cz * sx);
            coef_q15[8] = to_coef(cy * cx);
        endfunction

        function void set_angle(logic [CFG_IDX_W-1:0] idx, t_angle value);
            case (idx)
                REG_ANGLE_X: angle_reg[0] = value;
                REG_ANGLE_Y: angle_reg[1] = value;
                REG_ANGLE_Z: angle_reg[2] = value;
                default: return;
            endcase
            rebuild_matrix();
        endfunction

        // accepted point request: queue its rotated image
        function void note_point(t_coord x, t_coord y, t_coord z);
            longint in_c [3];
            longint out_c [3];
            longint acc;
            vec3_t  r;
            in_c[0] = x;
            in_c[1] = y;
            in_c[2] = z;
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) begin
                    acc += coef_q15[3*i + j] * in_c[j];
                end
                out_c[i] = clamp_signed(round_half_away(acc, FRAC_BITS), COORD_BITS);
            end
            r.x = t_coord'(out_c[0]);
            r.y = t_coord'(out_c[1]);
            r.z = t_coord'(out_c[2]);
            expected_q.push_back(r);
        endfunction

        function void check_result(vec3_t got);
            vec3_t want;
            if (expected_q.size() == 0) begin
                $error("rotated point %0d %0d %0d with no request pending",
                       got.x, got.y, got.z);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.x !== want.x) begin
                $error("rotated_x mismatch: expected %0d, actual %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $error("rotated_y mismatch: expected %0d, actual %0d", want.y, got.y);
                errors++;
            end
            if (got.z !== want.z) begin
                $error("rotated_z mismatch: expected %0d, actual %0d", want.z, got.z);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    erv_point_if pt_if ();
    erv_rot_if   rot_if ();

    rotation_scoreboard board;
    int          src_idle_pct  = 14;
    int          sink_idle_pct = 14;
    int          stall_req     = 0;
    int          n_writes      = 0;
    int unsigned cycle_count   = 0;

    euler_rotate_vec3_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_if),
        .o_rot      (rot_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: check, random back-pressure, long hold-off on request
    initial begin
        vec3_t got;
        int    hold_left;
        int    stall_ack;
        hold_left = 0;
        stall_ack = 0;
        rot_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rot_if.ready <= 1'b0;
            end else begin
                if (rot_if.valid && rot_if.ready) begin
                    got.x = rot_if.rotated_x;
                    got.y = rot_if.rotated_y;
                    got.z = rot_if.rotated_z;
                    board.check_result(got);
                end
                if (hold_left != 0) begin
                    hold_left--;
                    rot_if.ready <= 1'b0;
                end else if (stall_ack != stall_req) begin
                    stall_ack = stall_req;
                    hold_left = HOLD_CYCLES;
                    rot_if.ready <= 1'b0;
                end else begin
                    rot_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
                end
            end
        end
    end

    // one point request, with random idle cycles ahead of it
    task automatic send_point(t_coord x, t_coord y, t_coord z);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid   <= 1'b1;
        pt_if.point_x <= x;
        pt_if.point_y <= y;
        pt_if.point_z <= z;
        do begin
            @(posedge i_clk);
        end while (!pt_if.ready);
        board.note_point(x, y, z);
    endtask

    task automatic drain_results();
        pt_if.valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // angle write only once the core has gone quiet
    task automatic write_angle(logic [CFG_IDX_W-1:0] idx, t_angle value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        board.set_angle(idx, value);
        n_writes++;
    endtask

    function automatic t_coord random_coord();
        case ($urandom_range(0, 9))
            0: return COORD_TOP;
            1: return COORD_BOTTOM;
            2: return t_coord'($urandom_range(0, 2)) - t_coord'(1);
            3, 4: return t_coord'($urandom_range(0, 4000)) - t_coord'(2000);
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_angle pick_angle();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return '1;
            2: return ANGLE_QTR;
            3: return 16'h8000;
            4: return 16'hC000;
            5: return 16'h2000;
            default: return t_angle'($urandom);
        endcase
    endfunction

    initial begin
        board = new();
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= REG_ANGLE_X;
        cfg_data      <= '0;
        pt_if.valid   <= 1'b0;
        pt_if.point_x <= '0;
        pt_if.point_y <= '0;
        pt_if.point_z <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity after reset: coordinates pass through unchanged
        send_point(COORD_TOP, COORD_BOTTOM, 0);
        send_point(COORD_BOTTOM, COORD_TOP, -1);
        send_point(1, -1, 24'sh123456);
        send_point(0, 0, 0);

        // 45 degrees about Z: corner points overflow and saturate
        write_angle(REG_ANGLE_Z, 16'h2000);
        send_point(COORD_TOP, COORD_TOP, 0);
        send_point(COORD_BOTTOM, COORD_BOTTOM, COORD_TOP);
        send_point(COORD_TOP, COORD_BOTTOM, COORD_BOTTOM);

        // half turn about Z: negating the most negative value saturates
        write_angle(REG_ANGLE_Z, 16'h8000);
        send_point(COORD_BOTTOM, COORD_BOTTOM, COORD_TOP);
        send_point(COORD_TOP, 1, -1);

        // all angles at the top of the range
        write_angle(REG_ANGLE_X, 16'hFFFF);
        write_angle(REG_ANGLE_Y, 16'hFFFF);
        write_angle(REG_ANGLE_Z, 16'hFFFF);
        send_point(COORD_TOP, COORD_TOP, COORD_TOP);
        send_point(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM);

        // write to an index past the last register leaves the matrix alone
        write_angle(REG_UNUSED, 16'h1234);
        send_point(COORD_TOP, 0, COORD_BOTTOM);
        send_point(-1, 1000, -1000);

        // quarter turns about X and Y, three-quarter turn about Z
        write_angle(REG_ANGLE_X, ANGLE_QTR);
        write_angle(REG_ANGLE_Y, ANGLE_QTR);
        write_angle(REG_ANGLE_Z, 16'hC000);
        send_point(COORD_TOP, COORD_BOTTOM, 12345);
        send_point(0, COORD_TOP, COORD_BOTTOM);

        // random phases: new angles, then a burst of random points
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            repeat ($urandom_range(1, 3)) begin
                write_angle(CFG_IDX_W'($urandom_range(0, 3)), pick_angle());
            end
            src_idle_pct  = (ph == QUIET_PHASE) ? 0 : 14;
            sink_idle_pct = (ph == QUIET_PHASE) ? 0 : 14;
            if (ph == HOLD_PHASE) begin
                stall_req++;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == PAUSE_PHASE && k == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                send_point(random_coord(), random_coord(), random_coord());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("checked %0d rotated points over %0d angle writes, %0d long output hold-off",
                 board.checked, n_writes, stall_req);
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
src/erv_pkg.sv
src/erv_point_if.sv
src/erv_rot_if.sv
src/erv_coef_gen.sv
src/erv_mac_pipe.sv
src/euler_rotate_vec3_core.sv
src/erv_checker.sv
tb/sv/euler_rotate_vec3_core_tb.sv
